// ===== rtl/dcr_pkg.sv =====
// shared constants, codes and types for the depth driven column remap unit
// no dependencies; compiled first

package dcr_pkg;

  // row store geometry
  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned AddrW    = $clog2(MaxWidth);

  // field widths
  localparam int unsigned ColorW   = 24;
  localparam int unsigned CoefW    = 24;
  localparam int unsigned DepthW   = 16;
  localparam int unsigned WidthW   = 12;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned SrcW     = CoefW + 2;

  // divider sequencing, one quotient bit per cycle
  localparam int unsigned DivSteps = CoefW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // configuration port
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned RegIdxW  = 1;
  localparam logic [RegIdxW-1:0] RegShift = 1'b0;
  localparam logic [RegIdxW-1:0] RegWidth = 1'b1;

  // register reset values
  localparam logic signed [CoefW-1:0] ShiftReset = -24'sd24000;
  localparam logic [WidthW-1:0]       WidthReset = 12'd640;

  // input commands
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdMap  = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] StCopied    = 2'd0;
  localparam logic [StatusW-1:0] StZeroDepth = 2'd1;
  localparam logic [StatusW-1:0] StOutside   = 2'd2;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // row store access request
  typedef struct packed {
    logic              wr_en;
    logic [AddrW-1:0]  wr_addr;
    logic [ColorW-1:0] wr_data;
    logic              rd_en;
    logic [AddrW-1:0]  rd_addr;
  } store_req_t;

endpackage

// ===== rtl/dcr_if.sv =====
// valid/ready channel interfaces for pixel items and results
// depends on dcr_pkg

interface dcr_in_if;
  import dcr_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [AddrW-1:0]  column;
  logic [ColorW-1:0] color_in;
  logic [DepthW-1:0] depth;

  modport source (output valid, command, column, color_in, depth, input ready);
  modport sink   (input valid, command, column, color_in, depth, output ready);
endinterface

interface dcr_out_if;
  import dcr_pkg::*;

  logic               valid;
  logic               ready;
  logic [ColorW-1:0]  color_out;
  logic [StatusW-1:0] status;

  modport source (output valid, color_out, status, input ready);
  modport sink   (input valid, color_out, status, output ready);
endinterface

// ===== rtl/dcr_div.sv =====
// sequential restoring divider: signed coefficient by unsigned depth
// gives quotient magnitude and sign, truncated toward zero; depends on dcr_pkg

module dcr_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [dcr_pkg::CoefW-1:0]    dividend_i,
  input  logic [dcr_pkg::DepthW-1:0]          divisor_i,
  output dcr_pkg::div_status_t                status_o,
  output logic [dcr_pkg::CoefW-1:0]           mag_o,
  output logic                                neg_o
);
  import dcr_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [DepthW-1:0]   rem_q, rem_d;
  logic [CoefW-1:0]    quo_q, quo_d;
  logic [DepthW-1:0]   dvs_q, dvs_d;
  logic                neg_q, neg_d;
  logic [DepthW:0]     trial;
  logic [DepthW:0]     diff;
  logic                fits;

  // one restoring step: shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[CoefW-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
  end

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[CoefW-1];
      quo_d  = dividend_i[CoefW-1] ? (-dividend_i) : dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DepthW-1:0] : trial[DepthW-1:0];
      quo_d = {quo_q[CoefW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign mag_o         = quo_q;
  assign neg_o         = neg_q;

endmodule

// ===== rtl/dcr_row_store.sv =====
// color row store: one write port, one read port, registered read data
// depends on dcr_pkg

module dcr_row_store (
  input  logic                         clk_i,
  input  dcr_pkg::store_req_t          req_i,
  output logic [dcr_pkg::ColorW-1:0]   rd_data_o
);
  import dcr_pkg::*;

  logic [ColorW-1:0] mem [MaxWidth];
  logic [ColorW-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/depth_driven_column_remap_unit.sv =====
// depth driven column remap unit: configuration registers, item sequencer,
// result register; depends on dcr_pkg, dcr_if, dcr_div, dcr_row_store
//
// usage
//   in_i carries items. a load (command 0) writes color_in into the row store
//   at column and gives no result. a map (command 1) forms the source column
//   column + shift_coefficient / depth (truncated toward zero) and returns
//   one result on out_o: the stored color and status 0, or black with
//   status 1 for zero depth or status 2 for a source outside the row.
//   the apb port holds shift_coefficient at 0x0 and row_width at 0x4;
//   write them only while the unit is idle.
// flow
//   a load writes the row store on its transfer, gives no result and leaves
//   in_i.ready high. a map holds in_i.ready low until its result is loaded:
//   the bit-serial divider runs first, then the range check and row store
//   read, then the result register loads.
// reset and stall
//   reset restores the register defaults and empties the result register;
//   the row store is not cleared and a column reads valid once loaded.
//   a result waiting on out_o does not block loads or a new map's start; a map
//   finishing while it waits holds its read data until the receiver takes it.

module depth_driven_column_remap_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dcr_in_if.sink                        in_i,
  dcr_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcr_pkg::PaddrW-1:0]    paddr,
  input  logic [dcr_pkg::ApbDataW-1:0]  pwdata,
  output logic [dcr_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  import dcr_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StRd   = 2'd2;

  logic signed [CoefW-1:0] shift_q;
  logic [WidthW-1:0]       width_q;
  logic [1:0]              state_q, state_d;
  logic [AddrW-1:0]        column_q;
  logic                    zero_q;
  logic [StatusW-1:0]      status_q, status_d;
  logic                    out_valid_q, out_valid_d;
  logic [ColorW-1:0]       out_color_q;
  logic [StatusW-1:0]      out_status_q;

  logic                    in_xfer;
  logic                    map_xfer;
  logic                    out_load;
  logic [RegIdxW-1:0]      reg_idx;
  logic                    cfg_wr;
  div_status_t             div_st;
  logic [CoefW-1:0]        div_mag;
  logic                    div_neg;
  store_req_t              st_req;
  logic [ColorW-1:0]       st_rdata;
  logic [WidthW-1:0]       width_eff;
  logic [SrcW-1:0]         col_ext;
  logic [SrcW-1:0]         mag_ext;
  logic [SrcW-1:0]         src;
  logic                    outside;

  // configuration registers
  assign reg_idx = paddr[PaddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= ShiftReset;
      width_q <= WidthReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegShift: shift_q <= pwdata[CoefW-1:0];
        RegWidth: width_q <= pwdata[WidthW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegShift: prdata = {{(ApbDataW-CoefW){shift_q[CoefW-1]}}, shift_q};
      RegWidth: prdata = {{(ApbDataW-WidthW){1'b0}}, width_q};
      default:  prdata = '0;
    endcase
  end

  // input transfer decode
  assign in_i.ready = (state_q == StIdle);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign map_xfer   = in_xfer && (in_i.command == CmdMap);

  dcr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (map_xfer),
    .dividend_i (shift_q),
    .divisor_i  (in_i.depth),
    .status_o   (div_st),
    .mag_o      (div_mag),
    .neg_o      (div_neg)
  );

  // source column and row range check
  assign width_eff = (width_q > WidthW'(MaxWidth)) ? WidthW'(MaxWidth) : width_q;
  assign col_ext   = {{(SrcW-AddrW){1'b0}}, column_q};
  assign mag_ext   = {{(SrcW-CoefW){1'b0}}, div_mag};
  assign src       = div_neg ? (col_ext - mag_ext) : (col_ext + mag_ext);
  assign outside   = src[SrcW-1] || (src >= {{(SrcW-WidthW){1'b0}}, width_eff});

  // row store access
  always_comb begin
    st_req.wr_en   = in_xfer && (in_i.command == CmdLoad);
    st_req.wr_addr = in_i.column;
    st_req.wr_data = in_i.color_in;
    st_req.rd_en   = (state_q == StDiv) && div_st.done;
    st_req.rd_addr = src[AddrW-1:0];
  end

  dcr_row_store u_store (
    .clk_i     (clk_i),
    .req_i     (st_req),
    .rd_data_o (st_rdata)
  );

  // item sequencer
  assign out_load = (state_q == StRd) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    case (state_q)
      StIdle: begin
        if (map_xfer) state_d = StDiv;
      end
      StDiv: begin
        if (div_st.done) begin
          state_d = StRd;
          if (zero_q)       status_d = StZeroDepth;
          else if (outside) status_d = StOutside;
          else              status_d = StCopied;
        end
      end
      StRd: begin
        if (out_load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (out_load)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (map_xfer) begin
      column_q <= in_i.column;
      zero_q   <= (in_i.depth == '0);
    end
    if (out_load) begin
      out_color_q  <= (status_q == StCopied) ? st_rdata : '0;
      out_status_q <= status_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.color_out = out_color_q;
  assign out_o.status    = out_status_q;

  // a map transfer always starts the divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_xfer |=> div_st.busy)
    else $error("divider not started by map transfer");

  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == StDiv))
    else $error("divider finished outside the divide phase");

  // no store write may land while a map is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_req.wr_en |-> (!div_st.busy && (state_q == StIdle)))
    else $error("row store write during a map");

  // a new result only comes from the read phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == StRd))
    else $error("result appeared without a row store read");

endmodule

// ===== tb/dcr_checker.sv =====
`timescale 1ns / 1ps
// checker for the depth driven column remap unit: watches item, result and apb
// transfers, predicts every remapped pixel and compares it with the result
// depends on dcr_pkg and dcr_if

module dcr_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dcr_in_if                            items_i,
  dcr_out_if                           results_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [dcr_pkg::PaddrW-1:0]   paddr_i,
  input  logic [dcr_pkg::ApbDataW-1:0] pwdata_i,
  input  logic                         pready_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import dcr_pkg::*;

  typedef struct packed {
    logic [ColorW-1:0]  color;
    logic [StatusW-1:0] status;
  } pixel_result_t;

  // shadow registers and row store
  logic signed [CoefW-1:0] coef_shadow;
  logic [WidthW-1:0]       row_width;
  logic [ColorW-1:0]       row_store [MaxWidth];
  pixel_result_t           remapped_q [$];
  int unsigned             mismatches;

  // expected pixel for one map transfer
  function automatic pixel_result_t remap_pixel(logic [AddrW-1:0]  column,
                                               logic [DepthW-1:0] depth);
    pixel_result_t res;
    int            limit;
    int            src;
    res.color = '0;
    if (depth == '0) begin
      res.status = StZeroDepth;
      return res;
    end
    // widths above the store size are capped
    limit = (row_width > MaxWidth) ? int'(MaxWidth) : int'(row_width);
    // int division truncates toward zero
    src = int'(column) + int'(coef_shadow) / int'(depth);
    if (src < 0 || src >= limit) begin
      res.status = StOutside;
    end else begin
      res.color  = row_store[src];
      res.status = StCopied;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_result_t want;
    if (!rst_ni) begin
      coef_shadow <= ShiftReset;
      row_width   <= WidthReset;
      remapped_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // result transfer against the oldest prediction
      if (results_i.valid && results_i.ready) begin
        if (remapped_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: color %06h status %0d",
                     results_i.color_out, results_i.status);
          end
          mismatches++;
        end else begin
          want = remapped_q.pop_front();
          if (want.color != results_i.color_out || want.status != results_i.status) begin
            if (mismatches < 10) begin
              $display("result mismatch: expected color %06h status %0d, got color %06h status %0d",
                       want.color, want.status, results_i.color_out, results_i.status);
            end
            mismatches++;
          end
        end
      end
      // item transfer: loads update the store, maps queue a prediction
      if (items_i.valid && items_i.ready) begin
        if (items_i.command == CmdLoad) begin
          row_store[items_i.column] = items_i.color_in;
        end else begin
          remapped_q.push_back(remap_pixel(items_i.column, items_i.depth));
        end
      end
      // register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PaddrW-1:2])
          RegShift: coef_shadow <= pwdata_i[CoefW-1:0];
          RegWidth: row_width   <= pwdata_i[WidthW-1:0];
          default: ;
        endcase
      end
      fail_count_o <= mismatches;
      pending_o    <= remapped_q.size();
    end
  end

endmodule

// ===== tb/depth_driven_column_remap_unit_test.sv =====
`timescale 1ns / 1ps
// top of the depth driven column remap unit testbench: clock, reset, pixel
// stimulus, result backpressure, apb writes and verdict
// depends on dcr_pkg, dcr_if, dcr_checker and the unit itself

module depth_driven_column_remap_unit_test;
  import dcr_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned PhaseItems  = 115;
  localparam int unsigned IdlePct     = 23;
  localparam int unsigned DrainCycles = 40;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PaddrW-1:0]       paddr;
  logic [ApbDataW-1:0]     pwdata;
  logic [ApbDataW-1:0]     prdata;
  logic                    pready;
  int unsigned             fail_count;
  int unsigned             pending;
  int unsigned             cycle_count = 0;
  logic                    steady;

  // register settings and loaded columns, used to shape stimulus
  logic signed [CoefW-1:0] cur_shift = ShiftReset;
  logic [WidthW-1:0]       cur_width = WidthReset;
  logic                    loaded [MaxWidth] = '{default: 1'b0};

  dcr_in_if  in_ch ();
  dcr_out_if out_ch ();

  depth_driven_column_remap_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dcr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .items_i      (in_ch),
    .results_i    (out_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("depth_driven_column_remap_unit verification failed");
      $finish;
    end
  end

  // result backpressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  function automatic int row_limit();
    return (cur_width > MaxWidth) ? int'(MaxWidth) : int'(cur_width);
  endfunction

  // one item transfer, with random gaps ahead of it
  task automatic send_item(logic cmd, logic [AddrW-1:0] column,
                           logic [ColorW-1:0] color, logic [DepthW-1:0] depth);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.column   <= column;
    in_ch.color_in <= color;
    in_ch.depth    <= depth;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic load_pixel(logic [AddrW-1:0] column, logic [ColorW-1:0] color);
    loaded[column] = 1'b1;
    send_item(CmdLoad, column, color, DepthW'($urandom));
  endtask

  // a source column inside the row is loaded first if it never was
  task automatic map_pixel(logic [AddrW-1:0] column, logic [DepthW-1:0] depth);
    int src;
    if (depth != '0) begin
      src = int'(column) + int'(cur_shift) / int'(depth);
      if (src >= 0 && src < row_limit() && !loaded[src]) begin
        load_pixel(AddrW'(src), ColorW'($urandom));
      end
    end
    send_item(CmdMap, column, ColorW'($urandom), depth);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait for the unit to go idle, then reprogram both registers
  task automatic set_config(logic signed [CoefW-1:0] shift, logic [WidthW-1:0] width);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    write_reg(RegShift, ApbDataW'(shift));
    write_reg(RegWidth, ApbDataW'(width));
    cur_shift = shift;
    cur_width = width;
  endtask

  // mostly maps, most aimed into the row, plus loads and zero depth
  task automatic random_item();
    int                pick;
    int                limit;
    int                col;
    int                target;
    logic [DepthW-1:0] depth;
    pick  = $urandom_range(99);
    limit = row_limit();
    if (pick < 30) begin
      load_pixel(AddrW'($urandom), ColorW'($urandom));
    end else if (pick < 36) begin
      map_pixel(AddrW'($urandom), '0);
    end else begin
      pick = $urandom_range(99);
      if (pick < 10) depth = 16'd1;
      else if (pick < 20) depth = '1;
      else if (pick < 50) depth = DepthW'($urandom_range(255, 1));
      else depth = DepthW'($urandom_range(65535, 1));
      col = $urandom_range(MaxWidth - 1);
      if (limit > 0 && $urandom_range(99) < 70) begin
        target = $urandom_range(limit - 1);
        target = target - int'(cur_shift) / int'(depth);
        if (target >= 0 && target < int'(MaxWidth)) col = target;
      end
      map_pixel(AddrW'(col), depth);
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    steady         <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CmdLoad;
    in_ch.column   <= '0;
    in_ch.color_in <= '0;
    in_ch.depth    <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed items under the reset settings
    load_pixel(11'd0, '1);
    load_pixel(11'd2047, '0);         // column past the row still lands in the store
    load_pixel(11'd6, 24'h5a3c0f);
    load_pixel(11'd7, 24'ha5c3f0);
    map_pixel(11'd2047, '0);          // zero depth wins over any range test
    map_pixel(11'd0, '0);
    map_pixel(11'd0, '1);             // shift truncates to zero
    map_pixel(11'd5, 16'd1);          // largest shift, far left of the row
    map_pixel(11'd10, 16'd7000);      // -3.43 truncates to -3, reads column 7
    map_pixel(11'd639, '1);           // last column of the row
    map_pixel(11'd640, '1);           // first column past the row
    map_pixel(11'd2000, 16'd13);      // mapped column past the row, source inside
    map_pixel(11'd0, 16'd24000);      // shift of -1 from column 0
    map_pixel(11'd1, 16'd24000);
    load_pixel(11'd0, 24'h123456);    // overwrite, then read again
    map_pixel(11'd1, 16'd24000);

    // random phases, extremes of both registers first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(24'h7fffff, 12'd2048);
        1: set_config(24'h800000, 12'hfff);
        2: set_config('0, 12'd1);
        3: set_config(CoefW'($urandom), '0);
        4: set_config(-24'sd24000 + CoefW'($urandom_range(4000)),
                      WidthW'($urandom_range(2048, 1)));
        default: set_config(CoefW'($urandom_range(262143)) - 24'd131072, 12'd640);
      endcase
      steady <= (ph == 1);
      repeat (PhaseItems) random_item();
    end

    // drain and verdict
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("depth_driven_column_remap_unit verification clean");
    end else begin
      $display("depth_driven_column_remap_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dcr_pkg.sv
rtl/dcr_if.sv
rtl/dcr_div.sv
rtl/dcr_row_store.sv
rtl/depth_driven_column_remap_unit.sv
tb/dcr_checker.sv
tb/depth_driven_column_remap_unit_test.sv
